FILE: rtl/ecf_pkg.sv
// Package for the eased color fade core: sequencer states, register indexes
// and fixed widths of the configuration port and color fields.
// No dependencies.
package ecf_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned FRAC_OUT_W = 17;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 2'd2;

  // Reset value of the phase step (about 1/100 of the fade per tick)
  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 16'd655;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_RAD,
    S_SQRT,
    S_EASE,
    S_BLEND,
    S_MIX,
    S_OUT
  } state_e;

endpackage

FILE: rtl/eased_color_fade_core.sv
// Eased RGBA color fade: per-tick phase update, ease-in-out circular curve
// and four channel blends, all computed bit-serially by one sequencer.
// Depends on ecf_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  tick in | in_valid_i / in_stall_o    | restart_i
//  result  | out_valid_o / out_stall_i  | color_o, eased_fraction_o, running_o,
//          |                            | done_res_o
//  config  | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// A tick of a running fade runs the shift-add square of the curve input, the
// two-bit-per-cycle square root and the serial blend multiply one after the
// other on a single sequencer, and the next tick is taken in the same cycle
// as the result appears. Idle ticks and the finishing tick skip these steps
// and go from accept straight to the output state, which loads the output
// register. One tick is in work at a time; the result sits in an output
// register, and the next tick is taken while it waits. Reset is asynchronous
// and active low and needs no clearing pass. A stalled result only holds the
// sequencer in its last state.
module eased_color_fade_core
  import ecf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Tick channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COLOR_W-1:0]    color_o,
  output logic [FRAC_OUT_W-1:0] eased_fraction_o,
  output logic                  running_o,
  output logic                  done_res_o
);

  // Widths that follow from the fraction size
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned PW    = ((F > 16) ? F : 16) + 2;   // phase
  localparam int unsigned XW    = PW + 1;                    // doubled phase
  localparam int unsigned DW    = ((F + 1) > 17) ? (F + 1) : 17; // curve distance
  localparam int unsigned PRW   = 2 * DW;                    // square
  localparam int unsigned SQW   = PRW - F;                   // scaled square
  localparam int unsigned EW    = F + 1;                     // eased weight
  localparam int unsigned RADW  = 2 * F + 2;                 // radicand
  localparam int unsigned REMW  = F + 4;                     // root remainder
  localparam int unsigned ACCW  = F + 10;                    // blend product
  localparam int unsigned CW    = $clog2(DW);

  localparam logic [PW-1:0]  ONE_P  = {{(PW-1){1'b0}}, 1'b1} << F;
  localparam logic [XW-1:0]  ONE_X  = {{(XW-1){1'b0}}, 1'b1} << F;
  localparam logic [XW-1:0]  TWO_X  = {{(XW-1){1'b0}}, 1'b1} << (F + 1);
  localparam logic [SQW-1:0] ONE_SQ = {{(SQW-1){1'b0}}, 1'b1} << F;
  localparam logic [EW-1:0]  ONE_R  = {1'b1, {F{1'b0}}};
  localparam logic [EW:0]    ONE_E  = {2'b01, {F{1'b0}}};

  // Configuration registers
  logic [STEP_W-1:0]  phase_step_q;
  logic [COLOR_W-1:0] start_color_q, end_color_q;

  // Fade state
  state_e             state_q, state_d;
  logic [PW-1:0]      phase_q, phase_d;
  logic               fading_q, fading_d;
  logic [COLOR_W-1:0] shown_color_q, shown_color_d;
  logic [EW-1:0]      blend_weight_q, blend_weight_d;
  logic               done_q, done_d;

  // Serial datapath
  logic               lower_q, lower_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [DW-1:0]      mcand_q, mcand_d;
  logic [DW-1:0]      mplier_q, mplier_d;
  logic [PRW-1:0]     prod_q, prod_d;
  logic [RADW-1:0]    radicand_q, radicand_d;
  logic [REMW-1:0]    rem_q, rem_d;
  logic [EW-1:0]      root_q, root_d;
  logic [EW-1:0]      eshift_q, eshift_d;
  logic signed [ACCW-1:0] acc_q [4];
  logic signed [ACCW-1:0] acc_d [4];

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [COLOR_W-1:0]    color_q, color_d;
  logic [FRAC_OUT_W-1:0] frac_q, frac_d;
  logic                  running_q, running_d;
  logic                  done_res_q, done_res_d;

  // Combinational helpers
  logic              fade_now;
  logic [PW-1:0]     phase_now;
  logic [XW-1:0]     x_w;
  logic              lower_w;
  logic [XW-1:0]     dfull_w;
  logic [DW:0]       msum_w;
  logic [SQW-1:0]    sq_w;
  logic [EW-1:0]     rad_w;
  logic [REMW-1:0]   rem_sh_w;
  logic [REMW-1:0]   trial_w;
  logic [EW:0]       esum_w;
  logic signed [8:0] diff_w [4];
  logic signed [ACCW-1:0] shifted_w [4];
  logic [COLOR_W-1:0] mix_w;

  // A restart clears the phase and starts the fade within the same tick
  assign fade_now  = restart_i | fading_q;
  assign phase_now = restart_i ? '0 : phase_q;

  // Curve input: distance of the doubled phase from the nearer end
  assign x_w     = {phase_q, 1'b0};
  assign lower_w = (x_w < ONE_X);
  always_comb begin
    if (lower_w) begin
      dfull_w = x_w;
    end else if (x_w >= TWO_X) begin
      dfull_w = x_w - TWO_X;
    end else begin
      dfull_w = TWO_X - x_w;
    end
  end

  // One shift-add step of the square
  assign msum_w = {1'b0, prod_q[PRW-1:DW]} + {1'b0, (mplier_q[0] ? mcand_q : '0)};

  // Radicand of the circle, clamped at zero
  assign sq_w  = prod_q[PRW-1:F];
  assign rad_w = (sq_w >= ONE_SQ) ? '0 : EW'(ONE_SQ - sq_w);

  // One digit of the restoring square root
  assign rem_sh_w = {rem_q[REMW-3:0], radicand_q[RADW-1 -: 2]};
  assign trial_w  = {1'b0, root_q, 2'b01};

  // Eased weight from the root, halved toward zero
  assign esum_w = lower_q ? (ONE_E - {1'b0, root_q}) : (ONE_E + {1'b0, root_q});

  // Per-channel difference and final blend
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff_w[k]    = $signed({1'b0, end_color_q[8*k +: 8]})
                   - $signed({1'b0, start_color_q[8*k +: 8]});
      shifted_w[k] = acc_q[k] >>> F;
      mix_w[8*k +: 8] = start_color_q[8*k +: 8] + shifted_w[k][7:0];
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    fading_d       = fading_q;
    shown_color_d  = shown_color_q;
    blend_weight_d = blend_weight_q;
    done_d         = done_q;
    lower_d        = lower_q;
    cnt_d          = cnt_q;
    mcand_d        = mcand_q;
    mplier_d       = mplier_q;
    prod_d         = prod_q;
    radicand_d     = radicand_q;
    rem_d          = rem_q;
    root_d         = root_q;
    eshift_d       = eshift_q;
    for (int k = 0; k < 4; k++) begin
      acc_d[k] = acc_q[k];
    end
    out_valid_d = out_valid_q & out_stall_i;
    color_d     = color_q;
    frac_d      = frac_q;
    running_d   = running_q;
    done_res_d  = done_res_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          done_d = 1'b0;
          if (!fade_now) begin
            blend_weight_d = '0;
            state_d        = S_OUT;
          end else if (phase_now > ONE_P) begin
            // Fade has passed its end: snap to the end color
            shown_color_d  = end_color_q;
            blend_weight_d = '0;
            phase_d        = '0;
            fading_d       = 1'b0;
            done_d         = 1'b1;
            state_d        = S_OUT;
          end else begin
            phase_d  = phase_now + PW'(phase_step_q);
            fading_d = 1'b1;
            state_d  = S_PREP;
          end
        end
      end
      S_PREP: begin
        lower_d  = lower_w;
        mcand_d  = DW'(dfull_w);
        mplier_d = DW'(dfull_w);
        prod_d   = '0;
        cnt_d    = CW'(DW - 1);
        state_d  = S_MUL;
      end
      S_MUL: begin
        prod_d   = {msum_w, prod_q[DW-1:1]};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_RAD;
        end
      end
      S_RAD: begin
        radicand_d = {1'b0, rad_w, {F{1'b0}}};
        rem_d      = '0;
        root_d     = '0;
        cnt_d      = CW'(F);
        state_d    = S_SQRT;
      end
      S_SQRT: begin
        if (rem_sh_w >= trial_w) begin
          rem_d  = rem_sh_w - trial_w;
          root_d = {root_q[EW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh_w;
          root_d = {root_q[EW-2:0], 1'b0};
        end
        radicand_d = radicand_q << 2;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_EASE;
        end
      end
      S_EASE: begin
        blend_weight_d = esum_w[EW:1];
        eshift_d       = esum_w[EW:1];
        for (int k = 0; k < 4; k++) begin
          acc_d[k] = '0;
        end
        cnt_d   = CW'(F);
        state_d = S_BLEND;
      end
      S_BLEND: begin
        // Weight bits enter most significant first
        for (int k = 0; k < 4; k++) begin
          acc_d[k] = (acc_q[k] <<< 1) + (eshift_q[EW-1] ? ACCW'(diff_w[k]) : '0);
        end
        eshift_d = eshift_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        shown_color_d = mix_w;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          color_d     = shown_color_q;
          frac_d      = FRAC_OUT_W'(blend_weight_q);
          running_d   = fading_q;
          done_res_d  = done_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and fade state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= '0;
      fading_q       <= 1'b0;
      shown_color_q  <= '0;
      blend_weight_q <= '0;
      done_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      phase_step_q   <= PHASE_STEP_RST;
      start_color_q  <= '0;
      end_color_q    <= '0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      fading_q       <= fading_d;
      shown_color_q  <= shown_color_d;
      blend_weight_q <= blend_weight_d;
      done_q         <= done_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PHASE_STEP:  phase_step_q  <= cfg_wdata_i[STEP_W-1:0];
          REG_START_COLOR: start_color_q <= cfg_wdata_i[COLOR_W-1:0];
          REG_END_COLOR:   end_color_q   <= cfg_wdata_i[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath and result payload registers
  always_ff @(posedge clk_i) begin
    lower_q    <= lower_d;
    cnt_q      <= cnt_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    prod_q     <= prod_d;
    radicand_q <= radicand_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    eshift_q   <= eshift_d;
    for (int k = 0; k < 4; k++) begin
      acc_q[k] <= acc_d[k];
    end
    color_q    <= color_d;
    frac_q     <= frac_d;
    running_q  <= running_d;
    done_res_q <= done_res_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign color_o          = color_q;
  assign eased_fraction_o = frac_q;
  assign running_o        = running_q;
  assign done_res_o       = done_res_q;

  // A finishing beat reports a stopped fade with zero weight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !running_o && (eased_fraction_o == '0))
    else $error("finishing beat shows a running fade or a nonzero weight");

  // The phase is cleared whenever no fade is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fading_q |-> (phase_q == '0))
    else $error("phase left nonzero while idle");

  // All multiplier bits are consumed when the square is complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RAD) |-> (mplier_q == '0))
    else $error("square finished with multiplier bits left");

  // The square root never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EASE) |-> (root_q <= ONE_R))
    else $error("square root above one");

  // An accepted tick makes the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("tick accepted without the sequencer leaving idle");

endmodule
